FILE: hw/rtl/assert_macros.svh
// assertion helpers included by the ramp lookup core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/gcrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcrl_pkg
// types and constants of the gradient color ramp lookup
// ----------------------------------------------------------------------------
package gcrl_pkg;

    localparam logic [16:0] POS_ONE = 17'h10000;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_LOOKUP = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_LOCKED   = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_BAD_SLOT = 2'd3
    } t_status;

    localparam logic [1:0] COMP_RED   = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_BLUE  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [16:0] point_pos;
        logic [7:0]  point_red;
        logic [7:0]  point_green;
        logic [7:0]  point_blue;
        logic [3:0]  point_slot;
        logic [9:0]  entry_index;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       scale_valid;
        logic [1:0] status;
    } t_out_word;

    typedef struct packed {
        logic [16:0] pos;
        logic [23:0] color;
    } t_point;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_EV,
        S_ADD_WR,
        S_REM_RD,
        S_REM_EV,
        S_CHK,
        S_CHK_EV0,
        S_CHK_EVL,
        S_LK_RD0,
        S_LK_RD1,
        S_LK_EV,
        S_MUL_BASE,
        S_MUL_DEN,
        S_CLAMP,
        S_MUL_A,
        S_MUL_B,
        S_DIV,
        S_OUT
    } t_state;

    function automatic logic [7:0] color_comp(input logic [23:0] c, input logic [1:0] k);
        case (k)
            COMP_RED:   return c[23:16];
            COMP_GREEN: return c[15:8];
            default:    return c[7:0];
        endcase
    endfunction

endpackage

FILE: hw/rtl/gcrl_point_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcrl_point_ram
// control point store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gcrl_point_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  gcrl_pkg::t_point i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output gcrl_pkg::t_point o_rdata
);
    import gcrl_pkg::*;

    t_point r_mem [DEPTH];
    t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // the sequencer never uses a read of an entry made in the cycle it writes it
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/gcrl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcrl_div
// restoring divider, eight quotient bits, one bit per cycle
// ----------------------------------------------------------------------------
module gcrl_div #(
    parameter int DW = 27,
    parameter int NW = 35
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [7:0]    o_quot
);
    logic          r_busy;
    logic          r_done;
    logic [2:0]    r_bit;
    logic [NW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [7:0]    r_q;
    logic [NW-1:0] shifted;

    // quotient is known to stay below 256
    assign shifted = NW'(r_div) << r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= 3'd7;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_bit  <= 3'd7;
            end else if (r_busy) begin
                r_bit <= r_bit - 3'd1;
                if (r_bit == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_div <= i_divisor;
            r_q   <= 8'd0;
        end else if (r_busy) begin
            if (r_rem >= shifted) begin
                r_rem        <= r_rem - shifted;
                r_q[r_bit]   <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: hw/rtl/gradient_color_ramp_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_color_ramp_lookup_core
// sorted gradient point table in a ram with one write and one read port, with ramp entry interpolation
// ----------------------------------------------------------------------------
// one word at a time; the next word is taken the cycle after its result is queued
// add: compares stored points from the top, shifting each larger one up, then writes;
//   remove: moves each later point down; both check the ends unless under two points remain
// lookup: walks the intervals, sets up the base, span and clamp, then multiplies twice and
//   divides for each of three components, then loads; clear and invalid scale load directly
// reset (synchronous, active low) empties the table and unlocks; ram is not cleared
module gradient_color_ramp_lookup_core #(
    parameter int MAX_POINTS  = 16,
    parameter int LUT_ENTRIES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gcrl_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gcrl_pkg::t_out_word o_out_word
);
    import gcrl_pkg::*;
    `include "assert_macros.svh"

    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int SW  = (CW > 4) ? CW : 4;
    localparam int LW  = (LUT_ENTRIES > 2) ? $clog2(LUT_ENTRIES) : 1;
    localparam int IXW = (LW > 10) ? LW : 10;
    localparam int PW  = LW + 17;
    localparam int NW  = PW + 8;
    localparam logic [LW-1:0] LAST  = LW'(LUT_ENTRIES - 1);
    localparam logic [CW-1:0] CMAX  = CW'(MAX_POINTS);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_valid, n_valid;
    logic          r_first_ok, n_first_ok;
    logic          r_locked;
    logic [1:0]    r_act, n_act;
    t_status       r_status, n_status;
    t_point        r_new, n_new;
    logic [AW-1:0] r_at, n_at;
    logic [AW-1:0] r_k, n_k;
    logic [AW-1:0] r_j, n_j;
    t_point        r_e0, n_e0;
    t_point        r_e1, n_e1;
    logic [PW-1:0] r_target, n_target;
    logic [PW-1:0] r_prod, n_prod;
    logic [PW-1:0] r_den, n_den;
    logic [PW-1:0] r_num, n_num;
    logic [PW-1:0] r_dmn, n_dmn;
    logic [NW-1:0] r_acc, n_acc;
    logic [1:0]    r_comp, n_comp;
    logic [7:0]    r_red, n_red;
    logic [7:0]    r_green, n_green;
    logic [7:0]    r_blue, n_blue;
    logic          r_o_valid, n_o_valid;
    t_out_word     r_o_word, n_o_word;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_point        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_point        mem_rdata;
    logic          div_start;
    logic          div_done;
    logic [7:0]    div_q;

    logic [LW-1:0] idx_c;
    logic [PW-1:0] walk_prod;

    gcrl_point_ram #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // the divider takes the full sum as it is formed
    gcrl_div #(
        .DW (PW),
        .NW (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_acc),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign idx_c = (IXW'(i_in_word.entry_index) > IXW'(LAST)) ? LAST
                 : LW'(i_in_word.entry_index);
    assign walk_prod = PW'(mem_rdata.pos) * PW'(LAST);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out_word  = r_o_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_valid   <= 1'b0;
            r_locked  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_valid   <= n_valid;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_locked <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_ok <= n_first_ok;
        r_act      <= n_act;
        r_status   <= n_status;
        r_new      <= n_new;
        r_at       <= n_at;
        r_k        <= n_k;
        r_j        <= n_j;
        r_e0       <= n_e0;
        r_e1       <= n_e1;
        r_target   <= n_target;
        r_prod     <= n_prod;
        r_den      <= n_den;
        r_num      <= n_num;
        r_dmn      <= n_dmn;
        r_acc      <= n_acc;
        r_comp     <= n_comp;
        r_red      <= n_red;
        r_green    <= n_green;
        r_blue     <= n_blue;
        r_o_word   <= n_o_word;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_valid    = r_valid;
        n_first_ok = r_first_ok;
        n_act      = r_act;
        n_status   = r_status;
        n_new      = r_new;
        n_at       = r_at;
        n_k        = r_k;
        n_j        = r_j;
        n_e0       = r_e0;
        n_e1       = r_e1;
        n_target   = r_target;
        n_prod     = r_prod;
        n_den      = r_den;
        n_num      = r_num;
        n_dmn      = r_dmn;
        n_acc      = r_acc;
        n_comp     = r_comp;
        n_red      = r_red;
        n_green    = r_green;
        n_blue     = r_blue;
        n_o_valid  = r_o_valid && i_out_stall;
        n_o_word   = r_o_word;
        mem_we     = 1'b0;
        mem_waddr  = r_at;
        mem_wdata  = r_new;
        mem_raddr  = '0;
        div_start  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act    = i_in_word.action;
                    n_status = STAT_OK;
                    n_red    = 8'd0;
                    n_green  = 8'd0;
                    n_blue   = 8'd0;
                    n_state  = S_OUT;
                    unique case (i_in_word.action)
                        ACT_ADD: begin
                            if (r_locked) begin
                                n_status = STAT_LOCKED;
                            end else if (r_count == CMAX) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_new.pos = (i_in_word.point_pos > POS_ONE) ? POS_ONE
                                          : i_in_word.point_pos;
                                n_new.color = {i_in_word.point_red, i_in_word.point_green,
                                               i_in_word.point_blue};
                                n_at    = AW'(r_count);
                                n_state = (r_count == '0) ? S_ADD_WR : S_ADD_RD;
                            end
                        end
                        ACT_CLEAR: begin
                            if (r_locked) begin
                                n_status = STAT_LOCKED;
                            end else begin
                                n_count = '0;
                                n_valid = 1'b0;
                            end
                        end
                        ACT_REMOVE: begin
                            if (r_locked) begin
                                n_status = STAT_LOCKED;
                            end else if (SW'(i_in_word.point_slot) >= SW'(r_count)) begin
                                n_status = STAT_BAD_SLOT;
                            end else begin
                                n_k     = AW'(i_in_word.point_slot);
                                n_state = S_REM_RD;
                            end
                        end
                        default: begin
                            if (r_valid) begin
                                n_target = PW'({idx_c, 16'd0});
                                n_j      = '0;
                                n_state  = S_LK_RD0;
                            end
                        end
                    endcase
                end
            end
            S_ADD_RD: begin
                mem_raddr = r_at - AW'(1);
                n_state   = S_ADD_EV;
            end
            S_ADD_EV: begin
                if (mem_rdata.pos > r_new.pos) begin
                    // shift the larger point up one slot
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    n_at      = r_at - AW'(1);
                    n_state   = (r_at == AW'(1)) ? S_ADD_WR : S_ADD_RD;
                end else begin
                    n_state = S_ADD_WR;
                end
            end
            S_ADD_WR: begin
                mem_we  = 1'b1;
                n_count = r_count + CW'(1);
                n_state = S_CHK;
            end
            S_REM_RD: begin
                if ((CW + 1)'(r_k) + (CW + 1)'(1) < (CW + 1)'(r_count)) begin
                    mem_raddr = r_k + AW'(1);
                    n_state   = S_REM_EV;
                end else begin
                    // end check below sets the flag again
                    n_count = r_count - CW'(1);
                    n_valid = 1'b0;
                    n_state = S_CHK;
                end
            end
            S_REM_EV: begin
                mem_we    = 1'b1;
                mem_waddr = r_k;
                mem_wdata = mem_rdata;
                n_k       = r_k + AW'(1);
                n_state   = S_REM_RD;
            end
            S_CHK: begin
                if (r_count < CW'(2)) begin
                    n_valid = 1'b0;
                    n_state = S_OUT;
                end else begin
                    mem_raddr = '0;
                    n_state   = S_CHK_EV0;
                end
            end
            S_CHK_EV0: begin
                n_first_ok = (mem_rdata.pos == 17'd0);
                mem_raddr  = AW'(r_count - CW'(1));
                n_state    = S_CHK_EVL;
            end
            S_CHK_EVL: begin
                n_valid = r_first_ok && (mem_rdata.pos == POS_ONE);
                n_state = S_OUT;
            end
            S_LK_RD0: begin
                mem_raddr = '0;
                n_state   = S_LK_RD1;
            end
            S_LK_RD1: begin
                n_e0      = mem_rdata;
                mem_raddr = AW'(1);
                n_state   = S_LK_EV;
            end
            S_LK_EV: begin
                // step forward while the right end lies below the target
                if (((CW + 1)'(r_j) + (CW + 1)'(2) < (CW + 1)'(r_count))
                        && (walk_prod < r_target)) begin
                    n_e0      = mem_rdata;
                    n_j       = r_j + AW'(1);
                    mem_raddr = r_j + AW'(2);
                end else begin
                    n_e1    = mem_rdata;
                    n_state = S_MUL_BASE;
                end
            end
            S_MUL_BASE: begin
                n_prod = PW'(r_e0.pos) * PW'(LAST);
                if (r_e1.pos <= r_e0.pos) begin
                    n_red   = color_comp(r_e0.color, COMP_RED);
                    n_green = color_comp(r_e0.color, COMP_GREEN);
                    n_blue  = color_comp(r_e0.color, COMP_BLUE);
                    n_state = S_OUT;
                end else begin
                    n_state = S_MUL_DEN;
                end
            end
            S_MUL_DEN: begin
                n_den   = PW'(r_e1.pos - r_e0.pos) * PW'(LAST);
                n_num   = (r_target > r_prod) ? (r_target - r_prod) : '0;
                n_comp  = COMP_RED;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                if (r_num > r_den) begin
                    n_num = r_den;
                    n_dmn = '0;
                end else begin
                    n_dmn = r_den - r_num;
                end
                n_state = S_MUL_A;
            end
            S_MUL_A: begin
                n_acc   = NW'(color_comp(r_e0.color, r_comp)) * NW'(r_dmn);
                n_state = S_MUL_B;
            end
            S_MUL_B: begin
                n_acc     = r_acc + NW'(color_comp(r_e1.color, r_comp)) * NW'(r_num);
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    case (r_comp)
                        COMP_RED:   n_red   = div_q;
                        COMP_GREEN: n_green = div_q;
                        default:    n_blue  = div_q;
                    endcase
                    if (r_comp == COMP_BLUE) begin
                        n_state = S_OUT;
                    end else begin
                        n_comp  = r_comp + 2'd1;
                        n_state = S_MUL_A;
                    end
                end
            end
            S_OUT: begin
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid            = 1'b1;
                    n_o_word.out_red     = r_red;
                    n_o_word.out_green   = r_green;
                    n_o_word.out_blue    = r_blue;
                    n_o_word.out_alpha   = ((r_act == ACT_LOOKUP) && r_valid) ? 8'hFF
                                         : 8'h00;
                    n_o_word.scale_valid = r_valid;
                    n_o_word.status      = r_status;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CMAX)
    `ASSERT_IMPLIES(a_valid_needs_two, i_clk, i_rst_n, r_valid, r_count >= CW'(2))
    `ASSERT_IMPLIES(a_alpha_valid, i_clk, i_rst_n, r_o_valid && (r_o_word.out_alpha != 8'h00), r_o_word.scale_valid)
endmodule

FILE: tb/gradient_ramp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_ramp_checker
// watches both word channels of the gradient ramp core, keeps its own copy of
// the point table, predicts each result word and compares it field by field
// ----------------------------------------------------------------------------
module gradient_ramp_checker #(
    parameter int MAX_POINTS  = 16,
    parameter int LUT_ENTRIES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  gcrl_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  gcrl_pkg::t_out_word i_out_word,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_lookups_valid
);
    import gcrl_pkg::*;

    logic [16:0] ramp_pos[MAX_POINTS];
    logic [23:0] ramp_color[MAX_POINTS];
    int unsigned ramp_count;
    logic        ramp_locked;
    t_out_word   expected_words[$];

    initial begin
        o_fail_count    = 0;
        o_lookups_valid = 0;
        o_pending       = 0;
    end

    function automatic bit ramp_is_valid();
        if (ramp_count < 2) return 0;
        return ramp_pos[0] == 17'd0 && ramp_pos[ramp_count - 1] == POS_ONE;
    endfunction

    function automatic logic [7:0] blend(input logic [7:0] c0, input logic [7:0] c1,
                                         input longint unsigned num,
                                         input longint unsigned den);
        longint unsigned n;
        n = (num > den) ? den : num;
        return 8'((longint'(c0) * (den - n) + longint'(c1) * n) / den);
    endfunction

    // applies one input word to the table copy and returns the result word
    function automatic t_out_word ramp_apply(input t_in_word w);
        t_out_word       r;
        int unsigned     at, j, k;
        logic [16:0]     pos;
        longint unsigned last, idx, target, p0, p1, base, num, den;
        r = '0;
        r.status = STAT_OK;
        case (t_action'(w.action))
            ACT_ADD: begin
                if (ramp_locked) r.status = STAT_LOCKED;
                else if (ramp_count >= MAX_POINTS) r.status = STAT_FULL;
                else begin
                    pos = (w.point_pos > POS_ONE) ? POS_ONE : w.point_pos;
                    at = ramp_count;
                    while (at > 0 && ramp_pos[at - 1] > pos) begin
                        ramp_pos[at]   = ramp_pos[at - 1];
                        ramp_color[at] = ramp_color[at - 1];
                        at--;
                    end
                    ramp_pos[at]   = pos;
                    ramp_color[at] = {w.point_red, w.point_green, w.point_blue};
                    ramp_count++;
                end
            end
            ACT_CLEAR: begin
                if (ramp_locked) r.status = STAT_LOCKED;
                else ramp_count = 0;
            end
            ACT_REMOVE: begin
                if (ramp_locked) r.status = STAT_LOCKED;
                else if (w.point_slot >= ramp_count) r.status = STAT_BAD_SLOT;
                else begin
                    for (k = w.point_slot; k + 1 < ramp_count; k++) begin
                        ramp_pos[k]   = ramp_pos[k + 1];
                        ramp_color[k] = ramp_color[k + 1];
                    end
                    ramp_count--;
                end
            end
            default: begin
                if (ramp_is_valid()) begin
                    last = LUT_ENTRIES - 1;
                    idx = (w.entry_index > last) ? last : w.entry_index;
                    target = idx * 65536;
                    j = 0;
                    while (j + 2 < ramp_count && longint'(ramp_pos[j + 1]) * last < target)
                        j++;
                    p0 = ramp_pos[j];
                    p1 = ramp_pos[j + 1];
                    if (p1 <= p0) begin
                        {r.out_red, r.out_green, r.out_blue} = ramp_color[j];
                    end else begin
                        base = p0 * last;
                        num = (target > base) ? target - base : 0;
                        den = (p1 - p0) * last;
                        r.out_red   = blend(ramp_color[j][23:16], ramp_color[j+1][23:16], num, den);
                        r.out_green = blend(ramp_color[j][15:8], ramp_color[j+1][15:8], num, den);
                        r.out_blue  = blend(ramp_color[j][7:0], ramp_color[j+1][7:0], num, den);
                    end
                    r.out_alpha = 8'd255;
                    o_lookups_valid++;
                end
            end
        endcase
        r.scale_valid = ramp_is_valid();
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            ramp_count  = 0;
            ramp_locked = 0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) ramp_locked = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                expected_words = {expected_words, ramp_apply(i_in_word)};
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("unexpected result word %h", i_out_word);
                end else begin
                    want = expected_words.pop_front();
                    if (want.out_red !== i_out_word.out_red
                            || want.out_green !== i_out_word.out_green
                            || want.out_blue !== i_out_word.out_blue
                            || want.out_alpha !== i_out_word.out_alpha
                            || want.scale_valid !== i_out_word.scale_valid
                            || want.status !== i_out_word.status) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected rgba %h %h %h %h v%b s%0d, got %h %h %h %h v%b s%0d",
                                want.out_red, want.out_green, want.out_blue, want.out_alpha,
                                want.scale_valid, want.status, i_out_word.out_red,
                                i_out_word.out_green, i_out_word.out_blue,
                                i_out_word.out_alpha, i_out_word.scale_valid,
                                i_out_word.status);
                    end
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives gradient edits and ramp lookups into the core with random gaps and
// stalls, toggles the lock between phases, and reports the checker verdict
// ----------------------------------------------------------------------------
module testbench;
    import gcrl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      cfg_we = 0;
    logic      cfg_wdata = 0;
    logic      in_valid = 0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1;
    t_out_word out_word;
    int        fail_count, pending, lookups_valid;
    int        cycle_count = 0;
    int        words_sent = 0;
    bit        long_hold = 0;

    always #5 i_clk = ~i_clk;

    gradient_color_ramp_lookup_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_word(out_word)
    );

    gradient_ramp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_word(out_word),
        .o_fail_count(fail_count), .o_pending(pending), .o_lookups_valid(lookups_valid)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall per word, or a long hold when asked
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                out_stall <= 1;
                repeat (300) @(negedge i_clk);
                long_hold = 0;
            end
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) gap = 0;
            out_stall <= (gap != 0);
            if (gap != 0) begin
                repeat (gap - 1) @(negedge i_clk);
                @(negedge i_clk);
                out_stall <= 0;
            end
            do @(posedge i_clk); while (!(out_valid && !out_stall));
        end
    end

    task automatic send_word(input t_in_word w, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            in_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1;
        in_word  <= w;
        do @(posedge i_clk); while (in_stall);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_and_idle();
        in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic set_lock(input bit value);
        drain_and_idle();
        cfg_we    <= 1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we <= 0;
    endtask

    function automatic t_in_word make_word(input t_action a, input logic [16:0] p,
                                           input logic [23:0] c, input logic [3:0] s,
                                           input logic [9:0] e);
        t_in_word w;
        w = '0;
        w.action = a;
        w.point_pos = p;
        {w.point_red, w.point_green, w.point_blue} = c;
        w.point_slot = s;
        w.entry_index = e;
        return w;
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        int pick;
        w = t_in_word'($bits(t_in_word)'({$urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 12) w.action = ACT_ADD;
        else if (pick < 15) w.action = ACT_CLEAR;
        else if (pick < 25) w.action = ACT_REMOVE;
        else w.action = ACT_LOOKUP;
        if ($urandom_range(0, 2) != 0) w.point_pos = 17'($urandom_range(0, 65536));
        return w;
    endfunction

    // builds a well-formed ramp with both ends and some inner points
    task automatic build_ramp(input int inner);
        send_word(make_word(ACT_CLEAR, 0, 0, 0, 0), 0);
        send_word(make_word(ACT_ADD, 17'd0, 24'($urandom), 0, 0), 0);
        send_word(make_word(ACT_ADD, POS_ONE, 24'($urandom), 0, 0), 0);
        repeat (inner)
            send_word(make_word(ACT_ADD, 17'($urandom_range(0, 65536)), 24'($urandom), 0, 0), 0);
    endtask

    initial begin
        t_in_word w;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: empty table, bad slot, extremes, equal positions, clamp
        send_word(make_word(ACT_LOOKUP, 0, 0, 0, 10'd0), 0);
        send_word(make_word(ACT_REMOVE, 0, 0, 4'd15, 0), 0);
        send_word(make_word(ACT_ADD, 17'h1FFFF, 24'hFFFFFF, 0, 0), 0);
        send_word(make_word(ACT_LOOKUP, 0, 0, 0, 10'd5), 0);
        send_word(make_word(ACT_ADD, 17'd0, 24'h000000, 0, 0), 0);
        send_word(make_word(ACT_ADD, 17'd32768, 24'hFF0080, 0, 0), 0);
        send_word(make_word(ACT_ADD, 17'd32768, 24'h00FF40, 0, 0), 0);
        send_word(make_word(ACT_LOOKUP, 0, 0, 0, 10'd0), 0);
        send_word(make_word(ACT_LOOKUP, 0, 0, 0, 10'd511), 0);
        send_word(make_word(ACT_LOOKUP, 0, 0, 0, 10'd512), 0);
        send_word(make_word(ACT_LOOKUP, 0, 0, 0, 10'd1023), 0);
        send_word(make_word(ACT_REMOVE, 0, 0, 4'd1, 0), 0);
        send_word(make_word(ACT_LOOKUP, 0, 0, 0, 10'd700), 0);
        repeat (14) send_word(make_word(ACT_ADD, 17'd65535, 24'h123456, 0, 0), 0);
        send_word(make_word(ACT_LOOKUP, 0, 0, 0, 10'd1022), 0);

        set_lock(1);
        send_word(make_word(ACT_ADD, 17'd100, 24'hABCDEF, 0, 0), 0);
        send_word(make_word(ACT_CLEAR, 0, 0, 0, 0), 0);
        send_word(make_word(ACT_REMOVE, 0, 0, 4'd0, 0), 0);
        send_word(make_word(ACT_LOOKUP, 0, 0, 0, 10'd300), 0);
        set_lock(0);
        send_word(make_word(ACT_CLEAR, 0, 0, 0, 0), 0);

        // random phases: mostly valid ramps with lookups, plus noise
        for (int ph = 0; ph < 8; ph++) begin
            build_ramp($urandom_range(0, 6));
            if (ph == 2) long_hold = 1;
            for (int n = 0; n < 40; n++) begin
                w = random_word();
                if ($urandom_range(0, 3) != 0) w.action = ACT_LOOKUP;
                send_word(w, long_hold);
            end
            if (ph == 4) begin
                set_lock(1);
                repeat (15) send_word(random_word(), 0);
                set_lock(0);
            end
        end
        drain_and_idle();
        for (int n = 0; n < 20; n++) send_word(random_word(), 0);

        in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        $display("run covered %0d words, %0d interpolated lookups, lock toggled",
                 words_sent, lookups_valid);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
